[src/dbte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot throttle encoder package
// Shared types, register indexes and constants of the encoder.
// ----------------------------------------------------------------------------
package dbte_pkg;

  localparam int unsigned MOTOR_COUNT = 4;
  localparam int unsigned FRAME_BITS  = 16;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION_INVERT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANKING_MS      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_BIT_COUNT   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_BIT_COUNT    = 4'd3;

  localparam logic [14:0] ZERO_BIT_RESET = 15'd19;
  localparam logic [14:0] ONE_BIT_RESET  = 15'd39;

  localparam logic [11:0] FWD_BASE    = 12'd48;
  localparam logic [11:0] REV_BASE    = 12'd1048;
  localparam logic [11:0] FWD_MAX     = 12'd1047;
  localparam logic [11:0] REV_MAX     = 12'd2047;
  localparam logic [10:0] TELEM_LIMIT = 11'd24;

  localparam logic [4:0]  SLOT_LAST = 5'd16;
  localparam logic [15:0] POLARITY  = 16'h8000;

  typedef struct packed {
    logic [1:0]        motor;
    logic signed [7:0] speed;
    logic              want_telemetry;
    logic [31:0]       now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  motor_out;
    logic [4:0]  slot;
    logic [15:0] compare_value;
    logic [15:0] frame;
    logic        last_slot;
  } out_t;

  typedef struct packed {
    logic [1:0]  motor;
    logic [15:0] frame;
  } job_t;

  typedef struct packed {
    logic [3:0]  direction_invert;
    logic [15:0] blanking_ms;
    logic [14:0] zero_bit_count;
    logic [14:0] one_bit_count;
  } cfg_t;

endpackage

[src/dbte_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot encoder front end
// Accepts throttle requests, applies reversal blanking and inversion, keeps
// the per-motor history and builds the 16-bit frame.
// ----------------------------------------------------------------------------
module dbte_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  dbte_pkg::in_t  req_i,
  input  dbte_pkg::cfg_t cfg_i,
  output logic           job_push_o,
  output dbte_pkg::job_t job_o
);

  logic signed [7:0] prev_cmd_q  [dbte_pkg::MOTOR_COUNT];
  logic [31:0]       drive_time_q[dbte_pkg::MOTOR_COUNT];

  logic signed [7:0] t;
  logic signed [7:0] t_neg;
  logic signed [7:0] prev;
  logic [6:0]        mag;
  logic [10:0]       mag10;
  logic [31:0]       elapsed;
  logic              motor_ok;
  logic              t_pos;
  logic              t_is_neg;
  logic              blanked;
  logic              drive_neg;
  logic              drive_pos;
  logic [11:0]       fwd_sum;
  logic [11:0]       rev_sum;
  logic [10:0]       value;
  logic [11:0]       v;
  logic [3:0]        csum;

  always_comb begin
    motor_ok = 32'(req_i.motor) < dbte_pkg::MOTOR_COUNT;
    t        = (req_i.speed == -8'sd128) ? -8'sd127 : req_i.speed;
    t_neg    = -t;
    t_is_neg = t[7];
    t_pos    = !t[7] && (t != 8'sd0);
    mag      = t_is_neg ? t_neg[6:0] : t[6:0];
    mag10    = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
    prev     = prev_cmd_q[req_i.motor];
    elapsed  = req_i.now_ms - drive_time_q[req_i.motor];
    blanked  = ((prev < 8'sd0 && t_pos) || (prev > 8'sd0 && t_is_neg)) &&
               (elapsed < {16'd0, cfg_i.blanking_ms});
    if (cfg_i.direction_invert[req_i.motor]) begin
      drive_neg = t_pos;
      drive_pos = t_is_neg;
    end else begin
      drive_neg = t_is_neg;
      drive_pos = t_pos;
    end
    fwd_sum = dbte_pkg::FWD_BASE + {1'b0, mag10};
    rev_sum = dbte_pkg::REV_BASE + {1'b0, mag10};
    if (blanked) begin
      value = 11'd0;
    end else if (drive_neg) begin
      value = (rev_sum > dbte_pkg::REV_MAX) ? dbte_pkg::REV_MAX[10:0] : rev_sum[10:0];
    end else if (drive_pos) begin
      value = (fwd_sum > dbte_pkg::FWD_MAX) ? dbte_pkg::FWD_MAX[10:0] : fwd_sum[10:0];
    end else begin
      value = 11'd0;
    end
    v    = {value, req_i.want_telemetry || (value < dbte_pkg::TELEM_LIMIT)};
    csum = v[3:0] ^ v[7:4] ^ v[11:8];
  end

  assign job_push_o  = accept_i && motor_ok;
  assign job_o.motor = req_i.motor;
  assign job_o.frame = {v, csum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dbte_pkg::MOTOR_COUNT; i++) begin
        prev_cmd_q[i]   <= 8'sd0;
        drive_time_q[i] <= 32'd0;
      end
    end else if (job_push_o && !blanked) begin
      prev_cmd_q[req_i.motor] <= t;
      if (t != 8'sd0) begin
        drive_time_q[req_i.motor] <= req_i.now_ms;
      end
    end
  end

endmodule

[src/dbte_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot encoder job queue
// Two-entry queue of built frames between the front end and the serializer.
// ----------------------------------------------------------------------------
module dbte_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  dbte_pkg::job_t wr_data_i,
  input  logic           rd_en_i,
  output dbte_pkg::job_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  dbte_pkg::job_t mem_q[2];
  logic           wr_ptr_q;
  logic           wr_ptr_d;
  logic           rd_ptr_q;
  logic           rd_ptr_d;
  logic [1:0]     count_q;
  logic [1:0]     count_d;

  assign full_o    = count_q == 2'd2;
  assign empty_o   = count_q == 2'd0;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en_i;
    rd_ptr_d = rd_ptr_q ^ rd_en_i;
    count_d  = count_q + {1'b0, wr_en_i} - {1'b0, rd_en_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[src/dbte_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot encoder slot serializer
// Takes frames from the queue and presents seventeen compare slots each.
// ----------------------------------------------------------------------------
module dbte_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dbte_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  dbte_pkg::job_t q_data_i,
  output logic           q_rd_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dbte_pkg::out_t out_data_o
);

  dbte_pkg::job_t job_q;
  logic           busy_q;
  logic           busy_d;
  logic [4:0]     slot_q;
  logic [4:0]     slot_d;
  logic           is_last;
  logic           take;
  logic [3:0]     bit_idx;
  logic           bit_val;

  always_comb begin
    is_last = slot_q == dbte_pkg::SLOT_LAST;
    take    = busy_q && pop_i;
    q_rd_o  = !q_empty_i && (!busy_q || (take && is_last));
    busy_d  = busy_q;
    slot_d  = slot_q;
    if (q_rd_o) begin
      busy_d = 1'b1;
      slot_d = 5'd0;
    end else if (take) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        slot_d = slot_q + 5'd1;
      end
    end
    bit_idx = 4'(dbte_pkg::FRAME_BITS - 1) - slot_q[3:0];
    bit_val = job_q.frame[bit_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= 5'd0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      job_q <= q_data_i;
    end
  end

  assign empty_o                  = !busy_q;
  assign out_data_o.motor_out     = job_q.motor;
  assign out_data_o.slot          = slot_q;
  assign out_data_o.frame         = job_q.frame;
  assign out_data_o.last_slot     = is_last;
  assign out_data_o.compare_value = is_last ? dbte_pkg::POLARITY :
      (dbte_pkg::POLARITY | {1'b0, bit_val ? cfg_i.one_bit_count : cfg_i.zero_bit_count});

endmodule

[src/dshot_bidirectional_throttle_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot bidirectional throttle encoder
// Turns signed per-motor throttle requests into DShot frames and streams
// seventeen PWM compare slots per frame.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  request   push / full             in_data_i  (motor, speed, telemetry, time)
//  slots     empty / pop             out_data_o (motor, slot, compare, frame)
//  config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each request yields seventeen slots, one per cycle while pop is held, so the
// serializer, not the front end, sets the sustained request rate.
// With the serializer idle, a taken request is written into the queue and then
// loaded into the serializer's job register, from which the first slot appears.
// A two-entry queue lets the front end keep taking requests while slots stall.
// Reset clears the motor history and loads the default bit counts.
// ----------------------------------------------------------------------------
module dshot_bidirectional_throttle_encoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  dbte_pkg::in_t                       in_data_i,
  output logic                                empty,
  input  logic                                pop,
  output dbte_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dbte_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [dbte_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  dbte_pkg::cfg_t cfg_q;
  dbte_pkg::job_t front_job;
  dbte_pkg::job_t q_data;
  logic           front_push;
  logic           q_full;
  logic           q_empty;
  logic           q_rd;
  logic           accept;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction_invert <= 4'd0;
      cfg_q.blanking_ms      <= 16'd0;
      cfg_q.zero_bit_count   <= dbte_pkg::ZERO_BIT_RESET;
      cfg_q.one_bit_count    <= dbte_pkg::ONE_BIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dbte_pkg::CFG_DIRECTION_INVERT: cfg_q.direction_invert <= cfg_data_i[3:0];
        dbte_pkg::CFG_BLANKING_MS:      cfg_q.blanking_ms      <= cfg_data_i;
        dbte_pkg::CFG_ZERO_BIT_COUNT:   cfg_q.zero_bit_count   <= cfg_data_i[14:0];
        dbte_pkg::CFG_ONE_BIT_COUNT:    cfg_q.one_bit_count    <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  dbte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (in_data_i),
    .cfg_i      (cfg_q),
    .job_push_o (front_push),
    .job_o      (front_job)
  );

  dbte_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_push),
    .wr_data_i (front_job),
    .rd_en_i   (q_rd),
    .rd_data_o (q_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  dbte_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

endmodule

[bench/tb_dshot_bidirectional_throttle_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot bidirectional throttle encoder testbench
// Drives throttle requests and register writes into the encoder and checks
// every PWM compare slot against a frame predictor kept in the bench. The
// run covers reversal blanking, direction inversion and the bit-count
// registers under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_dshot_bidirectional_throttle_encoder_core;
  import dbte_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 4'hF;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t in_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  in_t pend_q[$];
  out_t slot_q[$];
  out_t slot_want;

  logic [3:0] dir_invert = 4'd0;
  logic [15:0] blank_ms = 16'd0;
  logic [14:0] zero_cnt = ZERO_BIT_RESET;
  logic [14:0] one_cnt = ONE_BIT_RESET;
  int last_cmd[MOTOR_COUNT];
  logic [31:0] last_drive_ms[MOTOR_COUNT];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  logic [31:0] clock_ms = 32'd0;

  dshot_bidirectional_throttle_encoder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_slots(in_t req);
    int thr;
    int old;
    int mag;
    int raw;
    logic [10:0] val;
    logic [11:0] word;
    logic [15:0] frm;
    logic [31:0] since;
    out_t s;
    thr = int'($signed(req.speed));
    if (thr < -127) thr = -127;
    old = last_cmd[req.motor];
    since = req.now_ms - last_drive_ms[req.motor];
    val = '0;
    if (!(((old < 0 && thr > 0) || (old > 0 && thr < 0)) && since < 32'(blank_ms))) begin
      last_cmd[req.motor] = thr;
      if (dir_invert[req.motor]) thr = -thr;
      mag = (thr < 0) ? -thr : thr;
      if (thr < 0) begin
        raw = int'(REV_BASE) + 10 * mag;
        if (raw > int'(REV_MAX)) raw = int'(REV_MAX);
        val = 11'(raw);
        last_drive_ms[req.motor] = req.now_ms;
      end else if (thr > 0) begin
        raw = int'(FWD_BASE) + 10 * mag;
        if (raw > int'(FWD_MAX)) raw = int'(FWD_MAX);
        val = 11'(raw);
        last_drive_ms[req.motor] = req.now_ms;
      end
    end
    word = {val, req.want_telemetry || (val < TELEM_LIMIT)};
    frm = {word, word[3:0] ^ word[7:4] ^ word[11:8]};
    for (int k = 0; k <= int'(SLOT_LAST); k++) begin
      s.motor_out = req.motor;
      s.slot = 5'(k);
      s.frame = frm;
      s.last_slot = (k == int'(SLOT_LAST));
      if (k < FRAME_BITS)
        s.compare_value = POLARITY | {1'b0, frm[FRAME_BITS-1-k] ? one_cnt : zero_cnt};
      else
        s.compare_value = POLARITY;
      slot_q.push_back(s);
    end
  endfunction

  function automatic in_t make_request(logic [1:0] m, int spd, bit tel, logic [31:0] now);
    in_t r;
    r.motor = m;
    r.speed = 8'(spd);
    r.want_telemetry = tel;
    r.now_ms = now;
    return r;
  endfunction

  function automatic in_t rand_request();
    in_t r;
    r.motor = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: r.speed = 8'h80;
      1: r.speed = 8'sd127;
      2: r.speed = -8'sd127;
      3: r.speed = 8'sd0;
      4, 5: r.speed = 8'(int'($urandom_range(20)) - 10);
      default: r.speed = 8'($urandom);
    endcase
    r.want_telemetry = 1'($urandom_range(1));
    if ($urandom_range(4) == 0)
      clock_ms = $urandom;
    else
      clock_ms = clock_ms + $urandom_range(int'(blank_ms) + int'(blank_ms) / 2 + 4);
    r.now_ms = clock_ms;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      in_data_i <= '0;
    end else if (!push || !full) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        in_data_i <= pend_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (slot_q.size() == 0) begin
          $error("slot with no request waiting: motor_out %0d slot %0d",
                 out_data_o.motor_out, out_data_o.slot);
          err_cnt++;
        end else begin
          slot_want = slot_q.pop_front();
          if (out_data_o.motor_out !== slot_want.motor_out) begin
            $error("motor_out mismatch: expected %0d, actual %0d",
                   slot_want.motor_out, out_data_o.motor_out);
            err_cnt++;
          end
          if (out_data_o.slot !== slot_want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", slot_want.slot, out_data_o.slot);
            err_cnt++;
          end
          if (out_data_o.compare_value !== slot_want.compare_value) begin
            $error("compare_value mismatch: expected %h, actual %h",
                   slot_want.compare_value, out_data_o.compare_value);
            err_cnt++;
          end
          if (out_data_o.frame !== slot_want.frame) begin
            $error("frame mismatch: expected %h, actual %h", slot_want.frame, out_data_o.frame);
            err_cnt++;
          end
          if (out_data_o.last_slot !== slot_want.last_slot) begin
            $error("last_slot mismatch: expected %0d, actual %0d",
                   slot_want.last_slot, out_data_o.last_slot);
            err_cnt++;
          end
        end
      end
      if (push && !full) predict_slots(in_data_i);
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk_i); while (pend_q.size() != 0 || push || slot_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DIRECTION_INVERT: dir_invert = data[3:0];
      CFG_BLANKING_MS:      blank_ms = data[15:0];
      CFG_ZERO_BIT_COUNT:   zero_cnt = data[14:0];
      CFG_ONE_BIT_COUNT:    one_cnt = data[14:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] dir, logic [15:0] blank, logic [15:0] zero,
                           logic [15:0] one);
    write_reg(CFG_DIRECTION_INVERT, dir);
    write_reg(CFG_BLANKING_MS, blank);
    write_reg(CFG_ZERO_BIT_COUNT, zero);
    write_reg(CFG_ONE_BIT_COUNT, one);
    @(negedge clk_i);
  endtask

  task automatic run_random(int n_items, int idle_pct, int stall_pct, bit hold_mid);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (hold_mid && i == n_items / 2) drain();
      pend_q.push_back(rand_request());
    end
    drain();
  endtask

  initial begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      last_cmd[m] = 0;
      last_drive_ms[m] = 32'd0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    pend_q.push_back(make_request(2'd0, 0, 1'b0, 32'd0));
    pend_q.push_back(make_request(2'd0, 127, 1'b0, 32'd100));
    pend_q.push_back(make_request(2'd0, -128, 1'b0, 32'd200));
    pend_q.push_back(make_request(2'd1, 1, 1'b1, 32'hFFFF_FFFF));
    pend_q.push_back(make_request(2'd1, -1, 1'b0, 32'd0));
    pend_q.push_back(make_request(2'd2, 99, 1'b0, 32'd5));
    pend_q.push_back(make_request(2'd2, 100, 1'b1, 32'd6));
    pend_q.push_back(make_request(2'd3, -99, 1'b0, 32'd7));
    pend_q.push_back(make_request(2'd3, -100, 1'b0, 32'd8));
    drain();

    write_reg(CFG_DIRECTION_INVERT, 16'h0005);
    write_reg(CFG_BLANKING_MS, 16'd1000);
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
    @(negedge clk_i);
    pend_q.push_back(make_request(2'd0, 50, 1'b0, 32'd300));
    pend_q.push_back(make_request(2'd0, 50, 1'b0, 32'd1200));
    pend_q.push_back(make_request(2'd0, 0, 1'b0, 32'd1300));
    pend_q.push_back(make_request(2'd0, -5, 1'b1, 32'd1301));
    pend_q.push_back(make_request(2'd1, 5, 1'b0, 32'hFFFF_FF00));
    pend_q.push_back(make_request(2'd1, -5, 1'b0, 32'h0000_0010));
    pend_q.push_back(make_request(2'd2, -1, 1'b0, 32'h0000_0010));
    pend_q.push_back(make_request(2'd3, 127, 1'b0, 32'd5000));
    drain();

    write_reg(CFG_ZERO_BIT_COUNT, 16'h0000);
    write_reg(CFG_ONE_BIT_COUNT, 16'hFFFF);
    @(negedge clk_i);
    pend_q.push_back(make_request(2'd1, 127, 1'b1, 32'h7FFF_FFFF));
    drain();

    write_all(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    run_random(38, 0, 0, 1'b0);

    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    run_random(38, 55, 0, 1'b1);

    write_reg(4'($urandom_range(15, 4)), 16'($urandom));
    write_all(16'($urandom), 16'($urandom_range(3000)), 16'($urandom), 16'($urandom));
    run_random(38, 0, 55, 1'b0);

    write_all(16'($urandom), 16'd200, 16'd19, 16'd39);
    run_random(38, 27, 27, 1'b0);

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
